// ===== design/ttcw_pkg.sv =====
package ttcw_pkg;

  // default geometry of the screen store
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 256;

  // limits of the shown area, whatever the store holds
  localparam int COLS_LIMIT = 256;
  localparam int ROWS_LIMIT = 64;
  localparam int COLS_FLOOR = 4;
  localparam int ROWS_FLOOR = 1;

  localparam int TAB_STOP = 4;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEF_FG  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEF_BG  = 2'd3;

  localparam logic [8:0]  COLUMNS_RESET = 9'd80;
  localparam logic [6:0]  ROWS_RESET    = 7'd25;
  localparam logic [23:0] DEF_FG_RESET  = 24'hCCCCCC;
  localparam logic [23:0] DEF_BG_RESET  = 24'h050505;

  // command codes
  localparam logic [1:0] CMD_PUT    = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_SETCUR = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  // control characters
  localparam logic [15:0] CH_BS    = 16'h0008;
  localparam logic [15:0] CH_TAB   = 16'h0009;
  localparam logic [15:0] CH_LF    = 16'h000A;
  localparam logic [15:0] CH_CR    = 16'h000D;
  localparam logic [15:0] CH_DEL   = 16'h007F;
  localparam logic [15:0] CH_SPACE = 16'h0020;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] char_code;
    logic [23:0] fore_color;
    logic [23:0] back_color;
    logic [7:0]  col_pos;
    logic [5:0]  row_pos;
  } cmd_word_t;

  typedef struct packed {
    logic [7:0]  cursor_col;
    logic [5:0]  cursor_row;
    logic [15:0] cell_char;
    logic [23:0] cell_fore;
    logic [23:0] cell_back;
    logic        did_scroll;
  } rsp_word_t;

  typedef struct packed {
    logic [15:0] ch;
    logic [23:0] fg;
    logic [23:0] bg;
  } cell_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_PUT,
    ST_COPY,
    ST_DRAIN,
    ST_BLANK,
    ST_SCROLL_END,
    ST_CLEAR,
    ST_FINISH
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CR,
    OP_LF,
    OP_TAB_INIT,
    OP_PUT,
    OP_BS,
    OP_SETCUR,
    OP_READ,
    OP_CLEAR,
    OP_COPY,
    OP_DRAIN,
    OP_BLANK,
    OP_SCROLL_END,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t op;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       is_cr;
    logic       is_lf;
    logic       is_bs;
    logic       line_last;
    logic       col_wrap;
    logic       rows_one;
    logic       tab_last;
    logic       tab_zero;
    logic       x_last;
    logic       y_copy_last;
    logic       y_all_last;
    logic       rsp_free;
  } dp_status_t;

endpackage

// ===== design/ttcw_ram.sv =====
module ttcw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/ttcw_ctrl.sv =====
module ttcw_ctrl import ttcw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  dp_status_t status,
  output ctl_cmd_t   ctl
);

  ctl_state_t state;
  ctl_state_t state_next;
  ctl_state_t scroll_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // a single row has nothing to move up
  assign scroll_entry = status.rows_one ? ST_BLANK : ST_COPY;
  assign cmd_stall    = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    ctl.op     = OP_NONE;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          ctl.op     = OP_LOAD;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status.cmd)
          CMD_PUT: begin
            if (status.is_cr) begin
              ctl.op     = OP_CR;
              state_next = ST_FINISH;
            end else if (status.is_lf) begin
              ctl.op     = OP_LF;
              state_next = status.line_last ? scroll_entry : ST_FINISH;
            end else if (status.is_bs) begin
              ctl.op     = OP_BS;
              state_next = ST_FINISH;
            end else begin
              ctl.op     = OP_TAB_INIT;
              state_next = ST_PUT;
            end
          end
          CMD_CLEAR: begin
            state_next = ST_CLEAR;
          end
          CMD_SETCUR: begin
            ctl.op     = OP_SETCUR;
            state_next = ST_FINISH;
          end
          default: begin
            ctl.op     = OP_READ;
            state_next = ST_FINISH;
          end
        endcase
      end
      ST_PUT: begin
        ctl.op = OP_PUT;
        if (status.col_wrap && status.line_last) begin
          state_next = scroll_entry;
        end else if (status.tab_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_COPY: begin
        ctl.op = OP_COPY;
        if (status.x_last && status.y_copy_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        ctl.op     = OP_DRAIN;
        state_next = ST_BLANK;
      end
      ST_BLANK: begin
        ctl.op = OP_BLANK;
        if (status.x_last) begin
          state_next = ST_SCROLL_END;
        end
      end
      ST_SCROLL_END: begin
        ctl.op     = OP_SCROLL_END;
        state_next = status.tab_zero ? ST_FINISH : ST_PUT;
      end
      ST_CLEAR: begin
        ctl.op = OP_CLEAR;
        if (status.x_last && status.y_all_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.rsp_free) begin
          ctl.op     = OP_FINISH;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/ttcw_dpath.sv =====
module ttcw_dpath import ttcw_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF,
  localparam int COL_W  = $clog2(MAX_COLS),
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int DEPTH  = MAX_ROWS * (2 ** COL_W),
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_word_t             cmd_word,
  input  logic                  rsp_stall,
  output logic                  rsp_valid,
  output rsp_word_t             rsp_word,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ctl_cmd_t              ctl,
  output dp_status_t            status,
  output logic                  ram_we,
  output logic [ADDR_W-1:0]     ram_waddr,
  output cell_t                 ram_wdata,
  output logic                  ram_re,
  output logic [ADDR_W-1:0]     ram_raddr,
  input  cell_t                 ram_rdata
);

  localparam int COLS_HI = (MAX_COLS < COLS_LIMIT) ? MAX_COLS : COLS_LIMIT;
  localparam int ROWS_HI = (MAX_ROWS < ROWS_LIMIT) ? MAX_ROWS : ROWS_LIMIT;

  logic [8:0]  columns_cfg;
  logic [6:0]  rows_cfg;
  logic [23:0] def_fg;
  logic [23:0] def_bg;

  cmd_word_t   item;
  logic [7:0]  cur_col;
  logic [5:0]  cur_line;
  logic [2:0]  tab_left;
  logic [7:0]  scan_x;
  logic [5:0]  scan_y;
  logic        copy_pend;
  logic [ADDR_W-1:0] copy_addr;
  logic        read_ok;
  logic        scrolled;

  logic [8:0]  eff_cols;
  logic [6:0]  eff_rows;
  logic [7:0]  sat_col;
  logic [5:0]  sat_line;
  logic [8:0]  col_inc;
  logic [6:0]  line_inc;
  logic        col_wrap;
  logic        line_last;
  logic [7:0]  last_col;
  logic [5:0]  last_line;
  logic [7:0]  bs_col;
  logic [5:0]  bs_line;
  logic        is_tab;
  logic        read_hit;
  logic        x_last;
  cell_t       blank;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [5:0] row, logic [7:0] col);
    return ADDR_W'({ROW_W'(row), COL_W'(col)});
  endfunction

  // shown area, saturated into its legal range
  always_comb begin
    if (columns_cfg > 9'(COLS_HI)) begin
      eff_cols = 9'(COLS_HI);
    end else if (columns_cfg < 9'(COLS_FLOOR)) begin
      eff_cols = 9'(COLS_FLOOR);
    end else begin
      eff_cols = columns_cfg;
    end
    if (rows_cfg > 7'(ROWS_HI)) begin
      eff_rows = 7'(ROWS_HI);
    end else if (rows_cfg < 7'(ROWS_FLOOR)) begin
      eff_rows = 7'(ROWS_FLOOR);
    end else begin
      eff_rows = rows_cfg;
    end
  end

  assign last_col  = 8'(eff_cols - 9'd1);
  assign last_line = 6'(eff_rows - 7'd1);
  assign sat_col   = ({1'b0, cur_col} >= eff_cols) ? last_col : cur_col;
  assign sat_line  = ({1'b0, cur_line} >= eff_rows) ? last_line : cur_line;
  assign col_inc   = {1'b0, sat_col} + 9'd1;
  assign line_inc  = {1'b0, sat_line} + 7'd1;
  assign col_wrap  = (col_inc >= eff_cols);
  assign line_last = (line_inc >= eff_rows);
  assign is_tab    = (item.char_code == CH_TAB);
  assign read_hit  = ({1'b0, item.col_pos} < eff_cols) && ({1'b0, item.row_pos} < eff_rows);
  assign x_last    = (({1'b0, scan_x} + 9'd1) == eff_cols);
  assign blank     = '{ch: '0, fg: def_fg, bg: def_bg};

  // backspace target, wrapping to the end of the row above
  always_comb begin
    if (sat_col != 8'd0) begin
      bs_col  = sat_col - 8'd1;
      bs_line = sat_line;
    end else if (sat_line != 6'd0) begin
      bs_col  = last_col;
      bs_line = sat_line - 6'd1;
    end else begin
      bs_col  = '0;
      bs_line = '0;
    end
  end

  always_comb begin
    status.cmd         = item.cmd;
    status.is_cr       = (item.char_code == CH_CR);
    status.is_lf       = (item.char_code == CH_LF);
    status.is_bs       = item.char_code inside {CH_BS, CH_DEL};
    status.line_last   = line_last;
    status.col_wrap    = col_wrap;
    status.rows_one    = (eff_rows == 7'd1);
    status.tab_last    = (tab_left == 3'd1);
    status.tab_zero    = (tab_left == 3'd0);
    status.x_last      = x_last;
    status.y_copy_last = (({1'b0, scan_y} + 7'd2) == eff_rows);
    status.y_all_last  = (({1'b0, scan_y} + 7'd1) == eff_rows);
    status.rsp_free    = !rsp_valid || !rsp_stall;
  end

  // write port: a pending scroll copy always goes first
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = blank;
    if (copy_pend) begin
      ram_we    = 1'b1;
      ram_waddr = copy_addr;
      ram_wdata = ram_rdata;
    end else begin
      case (ctl.op)
        OP_PUT: begin
          ram_we    = 1'b1;
          ram_waddr = cell_addr(sat_line, sat_col);
          ram_wdata = '{ch: is_tab ? CH_SPACE : item.char_code,
                        fg: item.fore_color, bg: item.back_color};
        end
        OP_BS: begin
          ram_we    = 1'b1;
          ram_waddr = cell_addr(bs_line, bs_col);
        end
        OP_CLEAR: begin
          ram_we    = 1'b1;
          ram_waddr = cell_addr(scan_y, scan_x);
        end
        OP_BLANK: begin
          ram_we    = 1'b1;
          ram_waddr = cell_addr(last_line, scan_x);
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (ctl.op)
      OP_READ: begin
        ram_re    = read_hit;
        ram_raddr = cell_addr(item.row_pos, item.col_pos);
      end
      OP_COPY: begin
        ram_re    = 1'b1;
        ram_raddr = cell_addr(scan_y + 6'd1, scan_x);
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_LOAD) begin
      item <= cmd_word;
    end
    copy_addr <= cell_addr(scan_y, scan_x);
    if (ctl.op == OP_READ) begin
      read_ok <= read_hit;
    end
    if (ctl.op == OP_FINISH) begin
      rsp_word.cursor_col <= cur_col;
      rsp_word.cursor_row <= cur_line;
      rsp_word.did_scroll <= scrolled;
      if (item.cmd == CMD_READ && read_ok) begin
        rsp_word.cell_char <= ram_rdata.ch;
        rsp_word.cell_fore <= ram_rdata.fg;
        rsp_word.cell_back <= ram_rdata.bg;
      end else begin
        rsp_word.cell_char <= '0;
        rsp_word.cell_fore <= '0;
        rsp_word.cell_back <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_cfg <= COLUMNS_RESET;
      rows_cfg    <= ROWS_RESET;
      def_fg      <= DEF_FG_RESET;
      def_bg      <= DEF_BG_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COLUMNS: columns_cfg <= cfg_data[8:0];
        REG_ROWS:    rows_cfg    <= cfg_data[6:0];
        REG_DEF_FG:  def_fg      <= cfg_data[23:0];
        REG_DEF_BG:  def_bg      <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col   <= '0;
      cur_line  <= '0;
      tab_left  <= '0;
      scan_x    <= '0;
      scan_y    <= '0;
      copy_pend <= 1'b0;
      scrolled  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      copy_pend <= (ctl.op == OP_COPY);

      if (ctl.op == OP_FINISH) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      // scan walks on clear, copy and blank, holds on drain, parks at zero otherwise
      case (ctl.op)
        OP_CLEAR, OP_COPY, OP_BLANK: begin
          if (x_last) begin
            scan_x <= '0;
            scan_y <= scan_y + 6'd1;
          end else begin
            scan_x <= scan_x + 8'd1;
          end
        end
        OP_DRAIN: begin
        end
        default: begin
          scan_x <= '0;
          scan_y <= '0;
        end
      endcase

      case (ctl.op)
        OP_LOAD: begin
          tab_left <= '0;
          scrolled <= 1'b0;
        end
        OP_CR: begin
          cur_col  <= '0;
          cur_line <= sat_line;
        end
        OP_LF: begin
          cur_col  <= '0;
          cur_line <= line_last ? sat_line : line_inc[5:0];
        end
        OP_TAB_INIT: begin
          // a plain character is a tab of one
          if (is_tab) begin
            tab_left <= 3'(TAB_STOP) - 3'(sat_col % 8'(TAB_STOP));
          end else begin
            tab_left <= 3'd1;
          end
        end
        OP_PUT: begin
          tab_left <= tab_left - 3'd1;
          if (col_wrap) begin
            cur_col  <= '0;
            cur_line <= line_last ? sat_line : line_inc[5:0];
          end else begin
            cur_col  <= col_inc[7:0];
            cur_line <= sat_line;
          end
        end
        OP_BS: begin
          cur_col  <= bs_col;
          cur_line <= bs_line;
        end
        OP_SETCUR: begin
          if ({1'b0, item.col_pos} < eff_cols) begin
            cur_col <= item.col_pos;
          end
          if ({1'b0, item.row_pos} < eff_rows) begin
            cur_line <= item.row_pos;
          end
        end
        OP_CLEAR: begin
          cur_col  <= '0;
          cur_line <= '0;
        end
        OP_SCROLL_END: begin
          cur_line <= last_line;
          scrolled <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/text_terminal_cell_writer.sv =====
// channel   direction  handshake              word
// cmd       in         cmd_valid / cmd_stall  cmd_word (cmd_word_t)
// rsp       out        rsp_valid / rsp_stall  rsp_word (rsp_word_t)
// cfg       in         cfg_write              cfg_index, cfg_data
//
// one command word at a time, one response word per command; a word is accepted
// in idle and the next one can be taken as soon as the response is registered
// clear and scroll walk the screen memory one cell a cycle; a scroll copies every
// shown row below the first up by one, then blanks the last row (only the blank
// with a single row); a tab writes spaces up to the next stop (up to 4)
// reset (rst, synchronous) homes the cursor and restores the registers; the
// screen memory is not cleared and holds nothing meaningful until written
// rsp_stall only holds the response register; a new command is still accepted
// and then waits in finish until the response register frees
module text_terminal_cell_writer import ttcw_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  cmd_word_t             cmd_word,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_word_t             rsp_word,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // screen memory: rows at a power-of-two column stride
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int DEPTH  = MAX_ROWS * (2 ** COL_W);
  localparam int ADDR_W = $clog2(DEPTH);

  ctl_cmd_t          ctl;
  dp_status_t        status;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  cell_t             ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  cell_t             ram_rdata;

  // sequencer: decode, character loop, scroll and clear walks
  ttcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .status    (status),
    .ctl       (ctl)
  );

  // cursor, registers, scan counters, address generation, response register
  ttcw_dpath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd_word  (cmd_word),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp_word  (rsp_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .status    (status),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // one write and one registered read per cycle; scroll copies overlap the two
  ttcw_ram #(
    .WIDTH ($bits(cell_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  // only one command in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command accepted while another is in flight");

  // the scroll pipeline never writes the cell it is reading
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("screen memory read and write hit the same cell");

  // finishing a command always presents a response next cycle
  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.op == OP_FINISH |=> rsp_valid)
    else $error("finished command without a response");
`endif

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import ttcw_pkg::*;

  // run shape
  localparam int PHASES      = 13;
  localparam int PHASE_ITEMS = 160;
  localparam int BIG_ITEMS   = 30;
  localparam int AREA_CAP    = 1024;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 40;
  localparam int STALL_LIMIT = 150000;

  // largest shown area the block can take
  localparam int COLS_TOP = (MAX_COLS_DEF < COLS_LIMIT) ? MAX_COLS_DEF : COLS_LIMIT;
  localparam int ROWS_TOP = (MAX_ROWS_DEF < ROWS_LIMIT) ? MAX_ROWS_DEF : ROWS_LIMIT;

  typedef enum logic {STEP_CMD, STEP_GEOM} step_kind_t;

  // one row of the directed script; a geometry row takes its colors from word
  typedef struct {
    step_kind_t kind;
    cmd_word_t  word;
    bit         typed;
    rsp_word_t  reply;
    logic [8:0] cols;
    logic [6:0] rows;
  } script_step_t;

  // hand-written reply for a command word, if any
  typedef struct {
    bit        typed;
    rsp_word_t word;
  } reply_note_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cmd_valid = 1'b0;
  logic                  cmd_stall;
  cmd_word_t             cmd_word  = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  rsp_word_t             rsp_word;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  text_terminal_cell_writer dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the terminal: screen store, registers and cursor
  cell_t       screen [MAX_ROWS_DEF][MAX_COLS_DEF];
  logic [8:0]  sh_cols = COLUMNS_RESET;
  logic [6:0]  sh_rows = ROWS_RESET;
  logic [23:0] sh_fg   = DEF_FG_RESET;
  logic [23:0] sh_bg   = DEF_BG_RESET;
  int unsigned cur_x   = 0;
  int unsigned cur_y   = 0;
  bit          scrolled_now;

  rsp_word_t    awaited[$];
  reply_note_t  reply_notes[$];
  script_step_t script[$];

  int failures      = 0;
  int idle_run      = 0;
  bit sender_calm   = 1'b0;
  bit receiver_calm = 1'b0;
  bit hold_ask      = 1'b0;

  function automatic int unsigned clamp_span(int unsigned v, int unsigned lo, int unsigned hi);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  function automatic int unsigned span_cols();
    return clamp_span(sh_cols, COLS_FLOOR, COLS_TOP);
  endfunction

  function automatic int unsigned span_rows();
    return clamp_span(sh_rows, ROWS_FLOOR, ROWS_TOP);
  endfunction

  function automatic void blank_at(int unsigned y, int unsigned x);
    screen[y][x] = {16'h0000, sh_fg, sh_bg};
  endfunction

  // every shown row moves up one, the last shown row goes blank
  function automatic void scroll_up();
    int unsigned cols, rows, y, x;
    cols = span_cols();
    rows = span_rows();
    for (y = 0; y + 1 < rows; y++)
      for (x = 0; x < cols; x++) screen[y][x] = screen[y + 1][x];
    for (x = 0; x < cols; x++) blank_at(rows - 1, x);
    cur_y = rows - 1;
    scrolled_now = 1'b1;
  endfunction

  function automatic void line_feed();
    cur_x = 0;
    cur_y++;
    if (cur_y >= span_rows()) scroll_up();
  endfunction

  // plain character with wrap before and after the write
  function automatic void put_glyph(logic [15:0] ch, logic [23:0] fg, logic [23:0] bg);
    int unsigned cols;
    cols = span_cols();
    if (cur_x >= cols) line_feed();
    screen[cur_y][cur_x] = {ch, fg, bg};
    cur_x++;
    if (cur_x >= cols) line_feed();
  endfunction

  function automatic rsp_word_t emulate_command(cmd_word_t w);
    rsp_word_t   r;
    cell_t       c;
    int unsigned cols, rows, y, x, n;
    r = '0;
    scrolled_now = 1'b0;
    cols = span_cols();
    rows = span_rows();
    case (w.cmd)
      CMD_PUT: begin
        // a shrunken area pulls the cursor back inside first
        if (cur_x >= cols) cur_x = cols - 1;
        if (cur_y >= rows) cur_y = rows - 1;
        if (w.char_code == CH_CR) begin
          cur_x = 0;
        end else if (w.char_code == CH_LF) begin
          line_feed();
        end else if (w.char_code == CH_TAB) begin
          n = TAB_STOP - (cur_x % TAB_STOP);
          for (x = 0; x < n; x++) put_glyph(CH_SPACE, w.fore_color, w.back_color);
        end else if (w.char_code == CH_BS || w.char_code == CH_DEL) begin
          if (cur_x > 0) begin
            cur_x--;
          end else if (cur_y > 0) begin
            cur_y--;
            cur_x = cols - 1;
          end
          blank_at(cur_y, cur_x);
        end else begin
          put_glyph(w.char_code, w.fore_color, w.back_color);
        end
      end
      CMD_CLEAR: begin
        for (y = 0; y < rows; y++)
          for (x = 0; x < cols; x++) blank_at(y, x);
        cur_x = 0;
        cur_y = 0;
      end
      CMD_SETCUR: begin
        if (w.col_pos < cols) cur_x = w.col_pos;
        if (w.row_pos < rows) cur_y = w.row_pos;
      end
      CMD_READ: begin
        if (w.col_pos < cols && w.row_pos < rows) begin
          c = screen[w.row_pos][w.col_pos];
          r.cell_char = c.ch;
          r.cell_fore = c.fg;
          r.cell_back = c.bg;
        end
      end
    endcase
    r.cursor_col = 8'(cur_x);
    r.cursor_row = 6'(cur_y);
    r.did_scroll = scrolled_now;
    return r;
  endfunction

  // directed script builders
  function automatic void cmd_step(logic [1:0] op, logic [15:0] ch, logic [23:0] fg,
                                   logic [23:0] bg, logic [7:0] x, logic [5:0] y);
    script_step_t s;
    s.kind  = STEP_CMD;
    s.word  = {op, ch, fg, bg, x, y};
    s.typed = 1'b0;
    s.reply = '0;
    s.cols  = '0;
    s.rows  = '0;
    script.push_back(s);
  endfunction

  function automatic void typed_reply(logic [7:0] cx, logic [5:0] cy, logic [15:0] ch,
                                      logic [23:0] fg, logic [23:0] bg, logic sc);
    script[script.size() - 1].typed = 1'b1;
    script[script.size() - 1].reply = {cx, cy, ch, fg, bg, sc};
  endfunction

  function automatic void geom_step(logic [8:0] cols, logic [6:0] rows, logic [23:0] fg,
                                    logic [23:0] bg);
    script_step_t s;
    s.kind  = STEP_GEOM;
    s.word  = '0;
    s.word.fore_color = fg;
    s.word.back_color = bg;
    s.typed = 1'b0;
    s.reply = '0;
    s.cols  = cols;
    s.rows  = rows;
    script.push_back(s);
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pause_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // coordinate inside the shown span, leaning on its edges
  function automatic int unsigned near_edge(int unsigned span);
    int unsigned r;
    r = $urandom_range(0, 5);
    if (r == 0) return 0;
    if (r == 1) return span - 1;
    return $urandom_range(0, span - 1);
  endfunction

  function automatic cmd_word_t random_command();
    cmd_word_t   w;
    int unsigned pick;
    w.cmd        = CMD_PUT;
    w.char_code  = 16'($urandom);
    w.fore_color = 24'($urandom);
    w.back_color = 24'($urandom);
    w.col_pos    = 8'($urandom);
    w.row_pos    = 6'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      w.cmd = CMD_CLEAR;
    end else if (pick < 15) begin
      w.cmd = CMD_SETCUR;
      if ($urandom_range(0, 3) != 0) begin
        w.col_pos = 8'(near_edge(span_cols()));
        w.row_pos = 6'(near_edge(span_rows()));
      end
    end else if (pick < 33) begin
      w.cmd = CMD_READ;
      if ($urandom_range(0, 4) != 0) begin
        w.col_pos = 8'(near_edge(span_cols()));
        w.row_pos = 6'(near_edge(span_rows()));
      end
    end else begin
      // put character: control codes often, the rest printable or any code
      pick = $urandom_range(0, 99);
      if (pick < 8) w.char_code = CH_CR;
      else if (pick < 18) w.char_code = CH_LF;
      else if (pick < 26) w.char_code = CH_TAB;
      else if (pick < 31) w.char_code = CH_BS;
      else if (pick < 35) w.char_code = CH_DEL;
      else if (pick < 40) w.char_code = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      else if (pick < 70) w.char_code = 16'($urandom_range(32, 126));
    end
    return w;
  endfunction

  task automatic check_field(string name, logic [23:0] want, logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  // hold one command word until it is taken
  task automatic push_cmd(cmd_word_t w);
    cmd_word  <= w;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  // offer one word, then maybe leave a gap with valid low
  task automatic offer(cmd_word_t w, bit typed, rsp_word_t reply);
    int unsigned n;
    reply_notes.push_back('{typed, reply});
    push_cmd(w);
    n = sender_calm ? 0 : pause_len();
    if (n != 0) begin
      cmd_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // stop offering and wait until every response word is in
  task automatic drain_replies();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (awaited.size() != 0) @(posedge clk);
  endtask

  // geometry and default colors, written only with the block idle
  task automatic program_screen(logic [8:0] cols, logic [6:0] rows, logic [23:0] fg,
                                logic [23:0] bg);
    drain_replies();
    repeat (2) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_COLUMNS;
    cfg_data  <= 24'(cols);
    @(posedge clk);
    cfg_index <= REG_ROWS;
    cfg_data  <= 24'(rows);
    @(posedge clk);
    cfg_index <= REG_DEF_FG;
    cfg_data  <= fg;
    @(posedge clk);
    cfg_index <= REG_DEF_BG;
    cfg_data  <= bg;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // register writes land in the shadow at the same edge as in the block
  always @(posedge clk) begin
    if (!rst && cfg_write) begin
      case (cfg_index)
        REG_COLUMNS: sh_cols = cfg_data[8:0];
        REG_ROWS:    sh_rows = cfg_data[6:0];
        REG_DEF_FG:  sh_fg   = cfg_data;
        REG_DEF_BG:  sh_bg   = cfg_data;
      endcase
    end
  end

  // every accepted command word advances the shadow and queues its reply
  always @(posedge clk) begin : cmd_watch
    rsp_word_t   predicted;
    reply_note_t note;
    if (!rst && cmd_valid && !cmd_stall) begin
      predicted = emulate_command(cmd_word);
      note = reply_notes.pop_front();
      awaited.push_back(note.typed ? note.word : predicted);
    end
  end

  // each response word is matched against the oldest queued reply
  always @(posedge clk) begin : rsp_watch
    rsp_word_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited.size() == 0) begin
        $error("response word with no command outstanding");
        failures++;
      end else begin
        want = awaited.pop_front();
        check_field("cursor_col", want.cursor_col, rsp_word.cursor_col);
        check_field("cursor_row", want.cursor_row, rsp_word.cursor_row);
        check_field("cell_char", want.cell_char, rsp_word.cell_char);
        check_field("cell_fore", want.cell_fore, rsp_word.cell_fore);
        check_field("cell_back", want.cell_back, rsp_word.cell_back);
        check_field("did_scroll", want.did_scroll, rsp_word.did_scroll);
      end
    end
  end

  // no word moving on any port for too long means the block hung
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || cfg_write) begin
      idle_run <= 0;
    end else if (idle_run == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // receiver pacing: random stalls, plus one long hold-off on request
  initial begin : rsp_pacing
    int unsigned n;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (hold_ask) begin
        hold_ask = 1'b0;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_stall <= 1'b0;
      end else if (!receiver_calm) begin
        n = pause_len();
        if (n != 0) begin
          rsp_stall <= 1'b1;
          repeat (n) @(posedge clk);
          rsp_stall <= 1'b0;
        end
      end
    end
  end

  initial begin : stimulus
    int          p, i, n_items;
    int unsigned cols_eff;
    logic [8:0]  geo_c;
    logic [6:0]  geo_r;
    logic [23:0] geo_fg, geo_bg;

    // reset geometry: 80 x 25, cursor home, store undefined until cleared
    cmd_step(CMD_CLEAR, 16'h0, 24'h0, 24'h0, 8'd0, 6'd0);
    typed_reply(8'd0, 6'd0, 16'h0, 24'h0, 24'h0, 1'b0);
    cmd_step(CMD_READ, 16'h0, 24'h0, 24'h0, 8'd0, 6'd0);
    typed_reply(8'd0, 6'd0, 16'h0, DEF_FG_RESET, DEF_BG_RESET, 1'b0);
    // read outside the shown area answers zeros
    cmd_step(CMD_READ, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'd255, 6'd63);
    typed_reply(8'd0, 6'd0, 16'h0, 24'h0, 24'h0, 1'b0);
    cmd_step(CMD_SETCUR, 16'h0, 24'h0, 24'h0, 8'd79, 6'd24);
    typed_reply(8'd79, 6'd24, 16'h0, 24'h0, 24'h0, 1'b0);
    // out of range set cursor keeps both coordinates
    cmd_step(CMD_SETCUR, 16'h0, 24'h0, 24'h0, 8'd255, 6'd63);
    typed_reply(8'd79, 6'd24, 16'h0, 24'h0, 24'h0, 1'b0);
    // last cell: wrap then scroll
    cmd_step(CMD_PUT, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'd0, 6'd0);
    typed_reply(8'd0, 6'd24, 16'h0, 24'h0, 24'h0, 1'b1);
    cmd_step(CMD_READ, 16'h0, 24'h0, 24'h0, 8'd79, 6'd23);
    typed_reply(8'd0, 6'd24, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
    // backspace at column zero wraps to the end of the previous row
    cmd_step(CMD_PUT, CH_BS, 24'h0, 24'h0, 8'd0, 6'd0);
    typed_reply(8'd79, 6'd23, 16'h0, 24'h0, 24'h0, 1'b0);
    cmd_step(CMD_READ, 16'h0, 24'h0, 24'h0, 8'd79, 6'd23);
    typed_reply(8'd79, 6'd23, 16'h0, DEF_FG_RESET, DEF_BG_RESET, 1'b0);
    cmd_step(CMD_SETCUR, 16'h0, 24'h0, 24'h0, 8'd0, 6'd0);
    typed_reply(8'd0, 6'd0, 16'h0, 24'h0, 24'h0, 1'b0);
    // delete at home stays home
    cmd_step(CMD_PUT, CH_DEL, 24'h0, 24'h0, 8'd0, 6'd0);
    typed_reply(8'd0, 6'd0, 16'h0, 24'h0, 24'h0, 1'b0);
    cmd_step(CMD_PUT, 16'h0000, 24'h000000, 24'h000000, 8'd0, 6'd0);
    cmd_step(CMD_PUT, CH_TAB, 24'h00FF00, 24'h0000FF, 8'd0, 6'd0);
    cmd_step(CMD_PUT, CH_CR, 24'h0, 24'h0, 8'd0, 6'd0);
    cmd_step(CMD_PUT, CH_LF, 24'h0, 24'h0, 8'd0, 6'd0);
    cmd_step(CMD_PUT, 16'h004D, 24'h123456, 24'hABCDEF, 8'd0, 6'd0);
    cmd_step(CMD_READ, 16'h0, 24'h0, 24'h0, 8'd0, 6'd1);
    cmd_step(CMD_SETCUR, 16'h0, 24'h0, 24'h0, 8'd2, 6'd24);
    cmd_step(CMD_PUT, CH_LF, 24'h0, 24'h0, 8'd0, 6'd0);
    typed_reply(8'd0, 6'd24, 16'h0, 24'h0, 24'h0, 1'b1);
    // sizes below the floor saturate to 4 x 1, cursor left outside
    geom_step(9'd0, 7'd0, 24'h000000, 24'hFFFFFF);
    cmd_step(CMD_PUT, 16'h007E, 24'hAAAAAA, 24'h555555, 8'd0, 6'd0);
    cmd_step(CMD_READ, 16'h0, 24'h0, 24'h0, 8'd0, 6'd0);
    // tab pads across the wrap of a single row
    cmd_step(CMD_PUT, CH_TAB, 24'h0, 24'h0, 8'd0, 6'd0);
    typed_reply(8'd0, 6'd0, 16'h0, 24'h0, 24'h0, 1'b1);
    // sizes above the top saturate to 256 x 64; clearing defines the store
    geom_step(9'd511, 7'd127, 24'hFFFFFF, 24'h000000);
    cmd_step(CMD_CLEAR, 16'h0, 24'h0, 24'h0, 8'd0, 6'd0);
    typed_reply(8'd0, 6'd0, 16'h0, 24'h0, 24'h0, 1'b0);
    cmd_step(CMD_SETCUR, 16'h0, 24'h0, 24'h0, 8'd255, 6'd63);
    typed_reply(8'd255, 6'd63, 16'h0, 24'h0, 24'h0, 1'b0);
    cmd_step(CMD_PUT, 16'h0041, 24'h808080, 24'h7F7F7F, 8'd0, 6'd0);
    typed_reply(8'd0, 6'd63, 16'h0, 24'h0, 24'h0, 1'b1);
    cmd_step(CMD_READ, 16'h0, 24'h0, 24'h0, 8'd255, 6'd62);
    typed_reply(8'd0, 6'd63, 16'h0041, 24'h808080, 24'h7F7F7F, 1'b0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[k]) begin
      if (script[k].kind == STEP_GEOM)
        program_screen(script[k].cols, script[k].rows, script[k].word.fore_color,
                       script[k].word.back_color);
      else
        offer(script[k].word, script[k].typed, script[k].reply);
    end

    // random phases, each with its own geometry and pacing
    for (p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        geo_c = 9'd4;
        geo_r = 7'd1;
        geo_fg = 24'h000000;
        geo_bg = 24'hFFFFFF;
      end else if (p == 1) begin
        geo_c = 9'd256;
        geo_r = 7'd64;
        geo_fg = 24'hFFFFFF;
        geo_bg = 24'h000000;
      end else begin
        i = $urandom_range(0, 9);
        if (i == 0) geo_c = 9'($urandom_range(0, 3));
        else if (i == 1) geo_c = 9'($urandom_range(257, 511));
        else if (i == 2) geo_c = 9'd256;
        else geo_c = 9'($urandom_range(4, 48));
        i = $urandom_range(0, 9);
        if (i == 0) geo_r = 7'd0;
        else if (i == 1) geo_r = 7'($urandom_range(65, 127));
        else if (i == 2) geo_r = 7'd64;
        else geo_r = 7'($urandom_range(1, 10));
        // keep screen walks short on most phases
        cols_eff = clamp_span(geo_c, COLS_FLOOR, COLS_TOP);
        if (cols_eff * clamp_span(geo_r, ROWS_FLOOR, ROWS_TOP) > AREA_CAP)
          geo_r = 7'(AREA_CAP / cols_eff);
        geo_fg = 24'($urandom);
        geo_bg = 24'($urandom);
        if ($urandom_range(0, 4) == 0) geo_fg = 24'hFFFFFF;
        if ($urandom_range(0, 4) == 0) geo_bg = 24'h000000;
      end
      program_screen(geo_c, geo_r, geo_fg, geo_bg);

      sender_calm   = (p == 2) || (p % 5 == 4);
      receiver_calm = (p % 6 == 5);
      // receiver holds off while the sender keeps offering
      if (p == 2) hold_ask = 1'b1;
      n_items = (p == 1) ? BIG_ITEMS : PHASE_ITEMS;
      for (i = 0; i < n_items; i++) begin
        // sender pauses mid-phase until the block has answered everything
        if (p == 3 && i == n_items / 2) drain_replies();
        offer(random_command(), 1'b0, '0);
      end
    end

    drain_replies();
    repeat (SETTLE) @(posedge clk);
    if (awaited.size() != 0) failures++;
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
